/* src/pwab_pkg.sv */
package pwab_pkg;

	// Action codes carried in s_tuser
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// Configuration register indexes
	localparam logic CFG_BLEND_MODE  = 1'b0;
	localparam logic CFG_CLEAR_COLOR = 1'b1;

	localparam logic [31:0] CLEAR_COLOR_RESET = 32'hFF37_3737;

	// Source of the frame store write data
	typedef enum logic [1:0] {
		WSEL_COLOR,
		WSEL_CLEAR,
		WSEL_BLEND
	} wsel_t;

	typedef struct packed {
		logic  in_ready;
		logic  calc_addr;
		logic  ram_we;
		wsel_t wsel;
		logic  use_clr_addr;
		logic  clr_clear;
		logic  clr_step;
		logic  cap_rd;
		logic  calc_sum;
		logic  load_out;
	} cmd_t;

	typedef struct packed {
		logic act_write;
		logic act_read;
		logic act_clear;
		logic blend;
		logic on_screen;
		logic clr_last;
		logic out_free;
	} status_t;

endpackage

/* src/pixel_write_alpha_blend_top.sv */
// Channel | Signals                          | Contents
// --------+----------------------------------+--------------------------------------------
// in      | s_tvalid s_tready s_tdata s_tuser | tdata: pos_x, pos_y, pixel_color; tuser: action
// out     | m_tvalid m_tready m_tdata m_tuser | tdata: read_data; tuser: out_of_range
// config  | cfg_we cfg_addr cfg_wdata         | 0 blend_mode, 1 clear_color
//
// Flow: one item at a time through the state machine. Normal write and off-screen items
// pass accept, address, decide, done; read adds a read wait, alpha write a read wait and a
// blend (read, multiply, divide and write back through the single frame store port). Clear
// sweeps the store, one pixel per cycle. Reset is asynchronous, active low; the frame store
// is not cleared by it. The next item is accepted once a result sits in the output register,
// which holds while m_tready is low; a full output register stalls only the finishing item.
module pixel_write_alpha_blend_top import pwab_pkg::*; #(
	parameter int SCREEN_W = 256,
	parameter int SCREEN_H = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // pos_x[15:0], pos_y[31:16], pixel_color[63:32]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // read_data[31:0]
	output logic        m_tuser,   // out_of_range[0]
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_wdata
);

	cmd_t    cmd;
	status_t status;

	// sequencer: accept, address, dispatch, read wait / blend / clear sweep, result
	pwab_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.status  (status),
		.cmd     (cmd)
	);

	// clipping, address multiply, blend arithmetic, frame store and output register
	pwab_dp #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	assign s_tready = cmd.in_ready;

endmodule

/* src/pwab_ram.sv */
module pwab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* src/pwab_ctrl.sv */
module pwab_ctrl import pwab_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ADDR   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_RWAIT  = 3'd3;
	localparam logic [2:0] ST_BLEND  = 3'd4;
	localparam logic [2:0] ST_CLEAR  = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		cmd.wsel = WSEL_COLOR;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				cmd.calc_addr = 1'b1;
				cmd.clr_clear = 1'b1;
				state_d       = ST_DECIDE;
			end
			ST_DECIDE: begin
				priority if (status.act_clear) begin
					state_d = ST_CLEAR;
				end else if (status.act_write && status.on_screen && !status.blend) begin
					cmd.ram_we = 1'b1;
					state_d    = ST_DONE;
				end else if ((status.act_write || status.act_read) && status.on_screen) begin
					state_d = ST_RWAIT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_RWAIT: begin
				// stored pixel is on the RAM output now
				cmd.cap_rd   = status.act_read;
				cmd.calc_sum = 1'b1;
				state_d      = status.act_write ? ST_BLEND : ST_DONE;
			end
			ST_BLEND: begin
				cmd.ram_we = 1'b1;
				cmd.wsel   = WSEL_BLEND;
				state_d    = ST_DONE;
			end
			ST_CLEAR: begin
				cmd.ram_we       = 1'b1;
				cmd.wsel         = WSEL_CLEAR;
				cmd.use_clr_addr = 1'b1;
				cmd.clr_step     = 1'b1;
				if (status.clr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/pwab_dp.sv */
module pwab_dp import pwab_pkg::*; #(
	parameter int SCREEN_W = 256,
	parameter int SCREEN_H = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic        s_tvalid,
	input  logic [63:0] s_tdata,
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_wdata
);

	localparam int DEPTH = SCREEN_W * SCREEN_H;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int XW    = SCREEN_W > 1 ? $clog2(SCREEN_W) : 1;
	localparam int YW    = SCREEN_H > 1 ? $clog2(SCREEN_H) : 1;
	localparam logic [AW-1:0] W_C    = AW'(SCREEN_W);
	localparam logic [AW-1:0] LAST_C = AW'(DEPTH - 1);

	// configuration
	logic        blend_q;
	logic [31:0] clear_color_q;

	// captured item
	logic [1:0]  action_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [31:0] color_q;

	logic [AW-1:0] addr_q;
	logic          inside_q;
	logic [AW-1:0] clr_q;
	logic [31:0]   rd_q;
	logic [15:0]   sum_r_q, sum_g_q, sum_b_q;

	logic          out_valid_q;
	logic [31:0]   out_data_q;
	logic          out_oor_q;

	logic          inside_c;
	logic [AW-1:0] addr_c;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;
	logic [31:0]   blended;
	logic [7:0]    alpha;
	logic [7:0]    nalpha;

	function automatic logic [15:0] mix(input logic [7:0] a, input logic [7:0] na,
	                                    input logic [7:0] s, input logic [7:0] d);
		return 16'(16'(a) * 16'(s)) + 16'(16'(na) * 16'(d));
	endfunction

	// floor(n/255) for n up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] n);
		logic [16:0] t;
		t = 17'(n) + 17'd1 + 17'(n[15:8]);
		return t[15:8];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q       <= 1'b0;
			clear_color_q <= CLEAR_COLOR_RESET;
		end else if (cfg_we) begin
			if (cfg_addr == CFG_BLEND_MODE) begin
				blend_q <= cfg_wdata[0];
			end else if (cfg_addr == CFG_CLEAR_COLOR) begin
				clear_color_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_ready && s_tvalid) begin
			action_q <= s_tuser;
			x_q      <= s_tdata[15:0];
			y_q      <= s_tdata[31:16];
			color_q  <= s_tdata[63:32];
			rd_q     <= '0;
		end else if (cmd.cap_rd) begin
			rd_q <= ram_rdata;
		end
	end

	assign inside_c = !x_q[15] && !y_q[15] && (x_q < 16'(SCREEN_W)) && (y_q < 16'(SCREEN_H));
	assign addr_c   = AW'(x_q[XW-1:0]) + AW'(AW'(y_q[YW-1:0]) * W_C);

	always_ff @(posedge clk) begin
		if (cmd.calc_addr) begin
			addr_q   <= addr_c;
			inside_q <= inside_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_clear) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// blend: products and sum, registered, then the divide
	assign alpha  = color_q[31:24];
	assign nalpha = 8'd255 - alpha;

	always_ff @(posedge clk) begin
		if (cmd.calc_sum) begin
			sum_r_q <= mix(alpha, nalpha, color_q[23:16], ram_rdata[23:16]);
			sum_g_q <= mix(alpha, nalpha, color_q[15:8], ram_rdata[15:8]);
			sum_b_q <= mix(alpha, nalpha, color_q[7:0], ram_rdata[7:0]);
		end
	end

	assign blended = {8'hFF, div255(sum_r_q), div255(sum_g_q), div255(sum_b_q)};

	always_comb begin
		unique case (cmd.wsel)
			WSEL_CLEAR: ram_wdata = clear_color_q;
			WSEL_BLEND: ram_wdata = blended;
			default:    ram_wdata = color_q;
		endcase
	end

	assign ram_addr = cmd.use_clr_addr ? clr_q : addr_q;

	pwab_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= rd_q;
			out_oor_q  <= !inside_q && (action_q == ACT_WRITE || action_q == ACT_READ);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_oor_q;

	assign status.act_write = action_q == ACT_WRITE;
	assign status.act_read  = action_q == ACT_READ;
	assign status.act_clear = action_q == ACT_CLEAR;
	assign status.blend     = blend_q;
	assign status.on_screen = inside_q;
	assign status.clr_last  = clr_q == LAST_C;
	assign status.out_free  = !out_valid_q || m_tready;

endmodule

/* src/pwab_chk.sv */
module pwab_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an off-screen result never carries pixel data
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0)
		else $error("out-of-range result with data");

	// one item at a time: no acceptance in the cycle after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted back to back");

	// address and decide states precede the result load, so no result appears during them
	a_min_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> ##1 !m_tvalid)
		else $error("result too early");

endmodule

bind pixel_write_alpha_blend_top pwab_chk u_pwab_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
